// ----- src/peer_cidr_route_table_unit_defines.svh -----
// Assertion helpers shared by the route table checker.
`ifndef PEER_CIDR_ROUTE_TABLE_UNIT_DEFINES_SVH
`define PEER_CIDR_ROUTE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk and ignored while in reset.
`define PRT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and ignored while in reset.
`define PRT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/prt_pkg.sv -----
package prt_pkg;

    // Table dimensions.
    localparam int MAX_PEERS         = 16;
    localparam int PREFIXES_PER_PEER = 8;

    // Peer slot width is set by the found_peer and peer_id fields.
    localparam int PEER_W      = 4;
    localparam int PEERS_CNT_W = $clog2(MAX_PEERS + 1);
    localparam int PFX_CNT_W   = $clog2(PREFIXES_PER_PEER + 1);
    localparam int PFX_IDX_W   = (PREFIXES_PER_PEER > 1) ? $clog2(PREFIXES_PER_PEER) : 1;

    // Operation codes.
    localparam logic [2:0] OP_ADD_PEER   = 3'd0;
    localparam logic [2:0] OP_ADD_PREFIX = 3'd1;
    localparam logic [2:0] OP_DEST_LOOK  = 3'd2;
    localparam logic [2:0] OP_SRC_CHECK  = 3'd3;
    localparam logic [2:0] OP_INSTALL    = 3'd4;
    localparam logic [2:0] OP_INDEX_LOOK = 3'd5;

    // Result status codes.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_NOPEER = 2'd2;
    localparam logic [1:0] STAT_MISS   = 2'd3;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic [2:0]             op;
        logic [PEER_W-1:0]      peer_id;
        logic [31:0]            ip_addr;
        logic [5:0]             prefix_len;
        logic [31:0]            session_index;
        logic [PEERS_CNT_W-1:0] peers_in_use;
        logic                   start;
        logic                   scan_en;
        logic [PFX_IDX_W-1:0]   scan_idx;
    } prt_cmd_t;

    // Result handed from cell to cell; claim marks the first owner found.
    typedef struct packed {
        logic              claim;
        logic [1:0]        status;
        logic              hit;
        logic [PEER_W-1:0] found;
        logic              which;
    } prt_res_t;

    // Network mask for a prefix length of at most 32.
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0) begin
            m = 32'h0;
        end else begin
            m = 32'hFFFF_FFFF << (6'd32 - len);
        end
        return m;
    endfunction

endpackage

// ----- src/prt_cell.sv -----
module prt_cell
    import prt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [PEER_W-1:0] cell_idx,
    input  prt_cmd_t          cmd,
    input  prt_res_t          chain_in,
    output prt_res_t          chain_out
);

    // Prefix store of this peer; entries at or above the count never match.
    logic [31:0] pfx_net_mem [PREFIXES_PER_PEER];
    logic [5:0]  pfx_len_mem [PREFIXES_PER_PEER];

    logic [PFX_CNT_W-1:0] pfx_cnt_reg;
    logic                 cur_valid_reg;
    logic [31:0]          cur_index_reg;
    logic                 prev_valid_reg;
    logic [31:0]          prev_index_reg;
    logic                 allows_reg;
    logic                 full_reg;
    prt_res_t             chain_reg;

    logic     active;
    logic     sel;
    logic     new_slot;
    logic     pfx_full;
    logic     scan_match;
    logic     cur_hit;
    logic     prev_hit;
    logic     add_pfx;
    prt_res_t own;

    // This peer exists and, for addressed operations, is the one addressed.
    assign active   = PEERS_CNT_W'(cell_idx) < cmd.peers_in_use;
    assign sel      = active && (cell_idx == cmd.peer_id);
    assign new_slot = (cmd.peers_in_use == PEERS_CNT_W'(cell_idx))
                   && (cmd.peers_in_use < PEERS_CNT_W'(MAX_PEERS));
    assign pfx_full = pfx_cnt_reg >= PFX_CNT_W'(PREFIXES_PER_PEER);
    assign add_pfx  = cmd.start && (cmd.op == OP_ADD_PREFIX) && sel && !pfx_full;

    // One stored prefix is compared per scan cycle.
    assign scan_match = (PFX_CNT_W'(cmd.scan_idx) < pfx_cnt_reg)
        && ((cmd.ip_addr & len_mask(pfx_len_mem[cmd.scan_idx]))
            == pfx_net_mem[cmd.scan_idx]);

    // Session slot matches; the index lookup ignores index zero.
    assign cur_hit  = cur_valid_reg && (cur_index_reg == cmd.session_index);
    assign prev_hit = prev_valid_reg && (prev_index_reg == cmd.session_index);

    // Prefix store write, at the slot given by the current count.
    always_ff @(posedge aclk) begin
        if (add_pfx) begin
            pfx_net_mem[pfx_cnt_reg[PFX_IDX_W-1:0]] <= cmd.ip_addr & len_mask(cmd.prefix_len);
            pfx_len_mem[pfx_cnt_reg[PFX_IDX_W-1:0]] <= cmd.prefix_len;
        end
    end

    // Session slots carry no reset; the valid bits guard them.
    always_ff @(posedge aclk) begin
        if (cmd.start && (cmd.op == OP_INSTALL) && sel) begin
            cur_index_reg <= cmd.session_index;
            if (cur_valid_reg) begin
                prev_index_reg <= cur_index_reg;
            end
        end
    end

    // Per-peer control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pfx_cnt_reg    <= '0;
            cur_valid_reg  <= 1'b0;
            prev_valid_reg <= 1'b0;
            allows_reg     <= 1'b0;
            full_reg       <= 1'b0;
        end else if (cmd.start) begin
            allows_reg <= 1'b0;
            unique case (cmd.op)
                OP_ADD_PEER: begin
                    if (new_slot) begin
                        pfx_cnt_reg    <= '0;
                        cur_valid_reg  <= 1'b0;
                        prev_valid_reg <= 1'b0;
                    end
                end
                OP_ADD_PREFIX: begin
                    full_reg <= pfx_full;
                    if (add_pfx) begin
                        pfx_cnt_reg <= pfx_cnt_reg + PFX_CNT_W'(1);
                    end
                end
                OP_INSTALL: begin
                    if (sel) begin
                        cur_valid_reg <= 1'b1;
                        if (cur_valid_reg) begin
                            prev_valid_reg <= 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (cmd.scan_en && scan_match) begin
            allows_reg <= 1'b1;
        end
    end

    // Result this peer offers to the chain.
    always_comb begin
        own       = '0;
        own.found = cell_idx;
        unique case (cmd.op)
            OP_ADD_PREFIX: begin
                if (sel) begin
                    own.claim  = 1'b1;
                    own.status = full_reg ? STAT_FULL : STAT_OK;
                end
            end
            OP_DEST_LOOK: begin
                if (active && allows_reg) begin
                    own.claim  = 1'b1;
                    own.hit    = 1'b1;
                    own.status = STAT_OK;
                end
            end
            OP_SRC_CHECK: begin
                if (sel) begin
                    own.claim  = 1'b1;
                    own.hit    = allows_reg;
                    own.status = allows_reg ? STAT_OK : STAT_MISS;
                end
            end
            OP_INSTALL: begin
                if (sel) begin
                    own.claim  = 1'b1;
                    own.status = STAT_OK;
                end
            end
            OP_INDEX_LOOK: begin
                if (active && (cmd.session_index != 32'h0) && (cur_hit || prev_hit)) begin
                    own.claim  = 1'b1;
                    own.hit    = 1'b1;
                    own.status = STAT_OK;
                    own.which  = !cur_hit;
                end
            end
            default: begin
            end
        endcase
    end

    // Chain stage: an earlier claim passes on, otherwise this peer's result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= '0;
        end else begin
            chain_reg <= chain_in.claim ? chain_in : own;
        end
    end

    assign chain_out = chain_reg;

endmodule

// ----- src/prt_ctrl.sv -----
module prt_ctrl
    import prt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic [1:0]  m_tuser,
    output prt_cmd_t    cmd,
    input  prt_res_t    chain_res
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_CHAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]             state_reg,   state_next;
    logic [PFX_IDX_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [PEER_W-1:0]      chain_cnt_reg, chain_cnt_next;
    logic [PEERS_CNT_W-1:0] peers_reg;
    logic                   add_full_reg;
    logic [PEER_W-1:0]      add_slot_reg;

    logic [2:0]        op_reg;
    logic [PEER_W-1:0] peer_id_reg;
    logic [31:0]       ip_addr_reg;
    logic [5:0]        plen_reg;
    logic [31:0]       sidx_reg;

    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic [1:0] m_user_reg;

    logic       s_acc;
    logic       out_free;
    logic [5:0] plen_in;
    prt_res_t   res;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Prefix lengths above 32 count as 32.
    assign plen_in = (s_tdata[41:36] > 6'd32) ? 6'd32 : s_tdata[41:36];

    // Latch the accepted transaction.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg      <= s_tuser;
            peer_id_reg <= s_tdata[3:0];
            ip_addr_reg <= s_tdata[35:4];
            plen_reg    <= plen_in;
            sidx_reg    <= s_tdata[73:42];
        end
    end

    // Broadcast to the cells.
    always_comb begin
        cmd               = '0;
        cmd.op            = op_reg;
        cmd.peer_id       = peer_id_reg;
        cmd.ip_addr       = ip_addr_reg;
        cmd.prefix_len    = plen_reg;
        cmd.session_index = sidx_reg;
        cmd.peers_in_use  = peers_reg;
        cmd.start         = (state_reg == ST_START);
        cmd.scan_en       = (state_reg == ST_SCAN);
        cmd.scan_idx      = scan_cnt_reg;
    end

    // Next-state logic of the sequencer.
    always_comb begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        chain_cnt_next = chain_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next    = ST_SCAN;
                scan_cnt_next = '0;
            end
            ST_SCAN: begin
                scan_cnt_next = scan_cnt_reg + PFX_IDX_W'(1);
                if (scan_cnt_reg == PFX_IDX_W'(PREFIXES_PER_PEER - 1)) begin
                    state_next     = ST_CHAIN;
                    chain_cnt_next = '0;
                end
            end
            ST_CHAIN: begin
                chain_cnt_next = chain_cnt_reg + PEER_W'(1);
                if (chain_cnt_reg == PEER_W'(MAX_PEERS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            chain_cnt_reg <= '0;
        end else begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            chain_cnt_reg <= chain_cnt_next;
        end
    end

    // Peer count; a new peer takes the next free slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peers_reg <= '0;
        end else if ((state_reg == ST_START) && (op_reg == OP_ADD_PEER)
                     && (peers_reg < PEERS_CNT_W'(MAX_PEERS))) begin
            peers_reg <= peers_reg + PEERS_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_START) begin
            add_full_reg <= peers_reg >= PEERS_CNT_W'(MAX_PEERS);
            add_slot_reg <= peers_reg[PEER_W-1:0];
        end
    end

    // Final result: the chain's claim, or the default for the operation.
    always_comb begin
        res = '0;
        if (chain_res.claim) begin
            res = chain_res;
        end else begin
            unique case (op_reg) inside
                OP_ADD_PEER: begin
                    res.status = add_full_reg ? STAT_FULL : STAT_OK;
                    res.found  = add_full_reg ? '0 : add_slot_reg;
                end
                OP_ADD_PREFIX, OP_SRC_CHECK, OP_INSTALL: begin
                    res.status = STAT_NOPEER;
                end
                default: begin
                    res.status = STAT_MISS;
                end
            endcase
        end
    end

    // Output register; the next transaction may be accepted while it waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            m_data_reg <= {2'b00, res.which, res.found, res.hit};
            m_user_reg <= res.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- src/peer_cidr_route_table_unit.sv -----
// Channel  Direction  tuser                 tdata (lowest bit first)
// s_       in         op[2:0]               peer_id[3:0], ip_addr[31:0], prefix_len[5:0],
//                                           session_index[31:0], zero fill to 80 bits
// m_       out        status[1:0]           hit, found_peer[3:0], which_session, zero fill
//
// Every transaction passes from acceptance to a valid result through the start state,
// the scan state, in which every peer cell compares its stored prefixes one slot at a
// time, the chain state, in which the result walks the chain of peer cells, and the
// done state, which loads the output register. The next transaction is accepted once
// the sequencer is back in idle. One transaction is in flight at a time, and a stalled
// output holds the sequencer in its final state. Reset is synchronous, active low, and
// empties the table at once.
module peer_cidr_route_table_unit
    import prt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,    // peer_id, ip_addr, prefix_len, session_index
    input  logic [2:0]  s_tuser,    // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // hit, found_peer, which_session
    output logic [1:0]  m_tuser     // status
);

    prt_cmd_t cmd;
    prt_res_t chain [MAX_PEERS + 1];

    // Sequencer and stream handshake.
    prt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .chain_res (chain[MAX_PEERS])
    );

    // The head of the chain carries no claim.
    assign chain[0] = '0;

    // One cell per peer slot, in slot order.
    for (genvar i = 0; i < MAX_PEERS; i++) begin : g_cell
        prt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (PEER_W'(i)),
            .cmd       (cmd),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

endmodule

// ----- src/prt_checker.sv -----
`include "peer_cidr_route_table_unit_defines.svh"

module prt_checker
    import prt_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser
);

    // A hit is only ever reported with status ok.
    `PRT_ASSERT_IMP(a_hit_ok, m_tvalid && m_tdata[0], m_tuser == STAT_OK, "hit without ok status")

    // The previous session slot is only named on a hit.
    `PRT_ASSERT_IMP(a_which_hit, m_tvalid && m_tdata[5], m_tdata[0], "which_session set on a miss")

    // A missing peer reports slot zero.
    `PRT_ASSERT_IMP(a_nopeer_zero, m_tvalid && (m_tuser == STAT_NOPEER),
                    m_tdata[4:1] == 4'd0, "found_peer set on missing peer")

    // One transaction at a time: input is closed right after an acceptance.
    `PRT_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input reopened too early")

endmodule

bind peer_cidr_route_table_unit prt_checker u_prt_checker (.*);
